// ===== sv/pcr_pkg.sv =====
// Shared constants and types for the palette color remap block.
package pcr_pkg;

  localparam int ENTRIES = 256;
  localparam int RGB_W   = 24;
  localparam int ALPHA_W = 8;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;

  typedef logic [RGB_W-1:0]   rgb_t;
  typedef logic [ALPHA_W-1:0] alpha_t;
  typedef logic [CMD_W-1:0]   cmd_t;

  // A lookup request walking down the row of table cells.
  typedef struct packed {
    logic act;      // a request occupies this stage
    logic is_load;  // load request; otherwise a pixel lookup
    rgb_t color;    // key to find or insert
    rgb_t repl;     // replacement color for a load
    alpha_t alpha;  // pixel alpha
    logic hit;      // key was found in an earlier cell
    logic done;     // key was found, or load was stored, in an earlier cell
    rgb_t hit_val;  // value of the matching entry
  } probe_t;

endpackage

// ===== sv/pcr_if.sv =====
// Valid/ready channel interfaces for the remap block's items and results.
interface pcr_in_if import pcr_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   command;
  rgb_t   in_color;
  rgb_t   map_color;
  alpha_t in_alpha;

  modport source (output valid, command, in_color, map_color, in_alpha, input ready);
  modport sink   (input valid, command, in_color, map_color, in_alpha, output ready);
endinterface

interface pcr_out_if import pcr_pkg::*; ();
  logic   valid;
  logic   ready;
  rgb_t   out_color;
  alpha_t out_alpha;
  logic   matched;
  logic   overflowed;

  modport source (output valid, out_color, out_alpha, matched, overflowed, input ready);
  modport sink   (input valid, out_color, out_alpha, matched, overflowed, output ready);
endinterface

// ===== sv/pcr_cell.sv =====
// One table entry: stores a key/value pair and passes the request on.
module pcr_cell import pcr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   clear,
  input  probe_t probe_i,
  output probe_t probe_o
);

  logic   valid_r;
  rgb_t   key_r;
  rgb_t   val_r;
  probe_t probe_r;
  probe_t probe_nxt;
  logic   match;
  logic   place;

  // Entries fill from the front, so the first empty cell ends any search.
  assign match = probe_i.act && valid_r && !probe_i.hit && (key_r == probe_i.color);
  assign place = probe_i.act && probe_i.is_load && !valid_r && !probe_i.hit && !probe_i.done;

  always_comb begin
    probe_nxt = probe_i;
    if (match) begin
      probe_nxt.hit     = 1'b1;
      probe_nxt.done    = 1'b1;
      probe_nxt.hit_val = val_r;
    end else if (place) begin
      probe_nxt.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clear) begin
      valid_r <= 1'b0;
    end else if (place) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (place) begin
      key_r <= probe_i.color;
      val_r <= probe_i.repl;
    end else if (match && probe_i.is_load) begin
      val_r <= probe_i.repl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.act <= 1'b0;
    end else begin
      probe_r.act <= probe_nxt.act;
    end
  end

  always_ff @(posedge clk) begin
    probe_r.is_load <= probe_nxt.is_load;
    probe_r.color   <= probe_nxt.color;
    probe_r.repl    <= probe_nxt.repl;
    probe_r.alpha   <= probe_nxt.alpha;
    probe_r.hit     <= probe_nxt.hit;
    probe_r.done    <= probe_nxt.done;
    probe_r.hit_val <= probe_nxt.hit_val;
  end

  assign probe_o = probe_r;

endmodule

// ===== sv/palette_color_remap.sv =====
// Palette color remap: a row of ENTRIES table cells, each holding one color pair; a
// load or pixel item walks the row one cell per cycle. A load keeps the block busy until
// it leaves the last cell. A pixel result goes from the last cell into the result register
// and then into the output register, and the next item can follow once the result has
// moved on. A clear or an unused command leaves the block in its idle state.
// A pixel with alpha zero skips the table: its black, unmatched result goes straight
// into the result register. One item is in work at a time; a
// finished result waits in the output register while the next item goes in, and a result
// that cannot move into a stalled output register holds off the input.
module palette_color_remap import pcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pcr_in_if.sink     in_ch,
  pcr_out_if.source  out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       overflow_r, overflow_nxt;
  rgb_t       res_color_r, res_color_nxt;
  alpha_t     res_alpha_r, res_alpha_nxt;
  logic       res_match_r, res_match_nxt;
  logic       out_valid_r, out_valid_nxt;
  rgb_t       out_color_r;
  alpha_t     out_alpha_r;
  logic       out_match_r;
  logic       out_ovf_r;
  logic       accept;
  logic       clear;
  logic       out_load;
  probe_t     chain_p [ENTRIES+1];
  probe_t     chain_out;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign clear       = accept && (in_ch.command == CMD_CLEAR);

  // The request enters the first cell in the cycle it is accepted.
  always_comb begin
    chain_p[0].act     = accept && ((in_ch.command == CMD_LOAD) ||
                         ((in_ch.command == CMD_PIXEL) && (in_ch.in_alpha != '0)));
    chain_p[0].is_load = (in_ch.command == CMD_LOAD);
    chain_p[0].color   = in_ch.in_color;
    chain_p[0].repl    = in_ch.map_color;
    chain_p[0].alpha   = in_ch.in_alpha;
    chain_p[0].hit     = 1'b0;
    chain_p[0].done    = 1'b0;
    chain_p[0].hit_val = '0;
  end

  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    pcr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clear   (clear),
      .probe_i (chain_p[gi]),
      .probe_o (chain_p[gi+1])
    );
  end

  assign chain_out = chain_p[ENTRIES];
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    overflow_nxt  = overflow_r;
    res_color_nxt = res_color_r;
    res_alpha_nxt = res_alpha_r;
    res_match_nxt = res_match_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.command)
            CMD_CLEAR: overflow_nxt = 1'b0;
            CMD_LOAD:  state_nxt = ST_BUSY;
            CMD_PIXEL: begin
              if (in_ch.in_alpha == '0) begin
                res_color_nxt = '0;
                res_alpha_nxt = '0;
                res_match_nxt = 1'b0;
                state_nxt     = ST_DONE;
              end else begin
                state_nxt = ST_BUSY;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_BUSY: begin
        if (chain_out.act) begin
          if (chain_out.is_load) begin
            // A load that found neither its key nor a free cell is dropped.
            if (!chain_out.done) begin
              overflow_nxt = 1'b1;
            end
            state_nxt = ST_IDLE;
          end else begin
            res_color_nxt = chain_out.hit ? chain_out.hit_val : chain_out.color;
            res_alpha_nxt = chain_out.alpha;
            res_match_nxt = chain_out.hit;
            state_nxt     = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_color_r <= res_color_nxt;
    res_alpha_r <= res_alpha_nxt;
    res_match_r <= res_match_nxt;
    if (out_load) begin
      out_color_r <= res_color_r;
      out_alpha_r <= res_alpha_r;
      out_match_r <= res_match_r;
      out_ovf_r   <= overflow_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_color  = out_color_r;
  assign out_ch.out_alpha  = out_alpha_r;
  assign out_ch.matched    = out_match_r;
  assign out_ch.overflowed = out_ovf_r;

  a_chain_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain_out.act |-> (state_r == ST_BUSY))
    else $error("request left the cell row outside the busy state");

  a_no_launch_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !chain_p[0].act)
    else $error("request launched while a result is still held");

  a_overflow_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(overflow_r) |-> $past(chain_out.act && chain_out.is_load && !chain_out.done))
    else $error("overflow set without a dropped load");

  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.out_alpha == '0)) |->
      ((out_ch.out_color == '0) && !out_ch.matched))
    else $error("transparent pixel result is not black and unmatched");

endmodule

// ===== verif/palette_color_remap_test.sv =====
// Self-checking testbench for the palette color remap block: directed table, then random palettes.
module palette_color_remap_test import pcr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam cmd_t    CMD_UNUSED   = 2'd3;
  localparam int      RANDOM_ITEMS = 1400;
  localparam int      LONG_GAP     = 120;
  localparam int      MAX_REPORTS  = 10;
  localparam longint  LIMIT        = 1600 * (ENTRIES + 2 + 2 * LONG_GAP) * 3;
  localparam int      N_DIRECTED   = 19;

  typedef struct {
    rgb_t   color;
    alpha_t alpha;
    logic   matched;
    logic   ovf;
  } remap_t;

  typedef struct {
    cmd_t   cmd;
    rgb_t   color;
    rgb_t   repl;
    alpha_t alpha;
    bit     typed;
    remap_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  pcr_in_if  in_ch ();
  pcr_out_if out_ch ();

  palette_color_remap i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Predicted palette contents.
  rgb_t   pal_key [ENTRIES];
  rgb_t   pal_val [ENTRIES];
  int     pal_count;
  bit     pal_ovf;

  remap_t pending_pixels [$];
  rgb_t   key_pool [$];
  int     fails;
  longint cycle_cnt;
  bit     steady;

  // Rows with the typed flag set carry an expected pixel that is obvious by eye.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_PIXEL,  24'h000000, 24'h000000, 8'h00, 1'b1, '{24'h000000, 8'h00, 1'b0, 1'b0}},
    '{CMD_PIXEL,  24'hFFFFFF, 24'h000000, 8'hFF, 1'b1, '{24'hFFFFFF, 8'hFF, 1'b0, 1'b0}},
    '{CMD_PIXEL,  24'h123456, 24'hFFFFFF, 8'h01, 1'b1, '{24'h123456, 8'h01, 1'b0, 1'b0}},
    '{CMD_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_LOAD,   24'h000000, 24'hFFFFFF, 8'hFF, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_LOAD,   24'hFFFFFF, 24'h000000, 8'h00, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_LOAD,   24'h5A5AA5, 24'hA5A55A, 8'h33, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_PIXEL,  24'h000000, 24'h000000, 8'hFF, 1'b1, '{24'hFFFFFF, 8'hFF, 1'b1, 1'b0}},
    '{CMD_PIXEL,  24'hFFFFFF, 24'hFFFFFF, 8'h80, 1'b1, '{24'h000000, 8'h80, 1'b1, 1'b0}},
    '{CMD_PIXEL,  24'h5A5AA5, 24'h000000, 8'h7F, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_PIXEL,  24'h5A5AA4, 24'h000000, 8'hFE, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_LOAD,   24'hFFFFFF, 24'h0A0B0C, 8'h00, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_PIXEL,  24'hFFFFFF, 24'h000000, 8'h7F, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_PIXEL,  24'hFFFFFF, 24'h000000, 8'h00, 1'b1, '{24'h000000, 8'h00, 1'b0, 1'b0}},
    '{CMD_UNUSED, 24'h000000, 24'h000000, 8'h00, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_PIXEL,  24'h000000, 24'h000000, 8'h01, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_CLEAR,  24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b0, '{24'h0, 8'h0, 1'b0, 1'b0}},
    '{CMD_PIXEL,  24'h000000, 24'h000000, 8'hFF, 1'b1, '{24'h000000, 8'hFF, 1'b0, 1'b0}},
    '{CMD_PIXEL,  24'hFFFFFF, 24'h000000, 8'h40, 1'b1, '{24'hFFFFFF, 8'h40, 1'b0, 1'b0}}
  };

  function automatic int find_key(input rgb_t key);
    for (int i = 0; i < pal_count; i++) begin
      if (pal_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one item to the predicted palette and returns the pixel it yields, if any.
  function automatic void remap_predict(input cmd_t cmd, input rgb_t color, input rgb_t repl,
                                        input alpha_t alpha, output bit emits,
                                        output remap_t res);
    int slot;
    emits = 1'b0;
    res = '{24'h0, 8'h0, 1'b0, 1'b0};
    slot = find_key(color);
    case (cmd)
      CMD_CLEAR: begin
        pal_count = 0;
        pal_ovf = 1'b0;
      end
      CMD_LOAD: begin
        if (slot >= 0) begin
          pal_val[slot] = repl;
        end else if (pal_count < ENTRIES) begin
          pal_key[pal_count] = color;
          pal_val[pal_count] = repl;
          pal_count++;
        end else begin
          pal_ovf = 1'b1;
        end
      end
      CMD_PIXEL: begin
        emits = 1'b1;
        if (alpha != 0) begin
          res.color = (slot >= 0) ? pal_val[slot] : color;
          res.matched = (slot >= 0);
          res.alpha = alpha;
        end
        res.ovf = pal_ovf;
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, LONG_GAP);
  endfunction

  function automatic rgb_t rand_rgb();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'h000000;
    if (r == 1) return 24'hFFFFFF;
    return rgb_t'($urandom_range(0, 24'hFFFFFF));
  endfunction

  function automatic alpha_t rand_alpha();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 8'h00;
    if (r == 2) return 8'hFF;
    return alpha_t'($urandom_range(1, 255));
  endfunction

  // Presents one item and waits for its acceptance; called at a rising edge.
  task automatic drive_item(input cmd_t cmd, input rgb_t color, input rgb_t repl,
                            input alpha_t alpha, input bit typed, input remap_t typed_res);
    int     gap;
    bit     emits;
    remap_t res;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.in_color  <= color;
    in_ch.map_color <= repl;
    in_ch.in_alpha  <= alpha;
    do @(posedge clk); while (!in_ch.ready);
    remap_predict(cmd, color, repl, alpha, emits, res);
    if (emits) pending_pixels.push_back(typed ? typed_res : res);
  endtask

  // Holds the sender off until every expected pixel has come back.
  task automatic drain_pixels();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("palette_color_remap_test NOT OK");
      $finish;
    end
  end

  // Result side: random back-pressure with long open stretches.
  initial begin
    int hold;
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(20, 600);
      out_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    remap_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("unexpected pixel: color %06h alpha %02h matched %0b overflowed %0b",
                   out_ch.out_color, out_ch.out_alpha, out_ch.matched, out_ch.overflowed);
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.out_color !== want.color || out_ch.out_alpha !== want.alpha ||
            out_ch.matched !== want.matched || out_ch.overflowed !== want.ovf) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("pixel mismatch: expected %06h/%02h/%0b/%0b, got %06h/%02h/%0b/%0b",
                     want.color, want.alpha, want.matched, want.ovf,
                     out_ch.out_color, out_ch.out_alpha, out_ch.matched, out_ch.overflowed);
        end
      end
    end
  end

  initial begin
    int     sent;
    int     n_loads;
    int     n_pix;
    int     r;
    bit     first;
    bit     drained;
    rgb_t   c;
    remap_t none;
    none = '{24'h0, 8'h0, 1'b0, 1'b0};
    fails = 0;
    cycle_cnt = 0;
    pal_count = 0;
    pal_ovf = 1'b0;
    steady = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_CLEAR;
    in_ch.in_color  <= '0;
    in_ch.map_color <= '0;
    in_ch.in_alpha  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      drive_item(directed_rows[i].cmd, directed_rows[i].color, directed_rows[i].repl,
                 directed_rows[i].alpha, directed_rows[i].typed, directed_rows[i].want);

    // Random palettes: a clear, a run of loads, then mostly pixels drawn from the keys.
    // The first palette gets more loads than ENTRIES, but repeated keys need not overfill it.
    sent = 0;
    first = 1'b1;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      key_pool.delete();
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        drain_pixels();
        drained = 1'b1;
      end
      drive_item(CMD_CLEAR, rand_rgb(), rand_rgb(), rand_alpha(), 1'b0, none);
      sent++;
      if (first) n_loads = ENTRIES + $urandom_range(2, 6);
      else if ($urandom_range(0, 9) == 0) n_loads = 0;
      else n_loads = $urandom_range(1, 24);
      first = 1'b0;
      for (int k = 0; k < n_loads; k++) begin
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 15)
          c = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
          c = rand_rgb();
        key_pool.push_back(c);
        drive_item(CMD_LOAD, c, rand_rgb(), rand_alpha(), 1'b0, none);
        sent++;
      end
      n_pix = $urandom_range(10, 50);
      for (int k = 0; k < n_pix; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          drive_item(CMD_UNUSED, rand_rgb(), rand_rgb(), rand_alpha(), 1'b0, none);
        end else if (r < 12) begin
          c = rand_rgb();
          key_pool.push_back(c);
          drive_item(CMD_LOAD, c, rand_rgb(), rand_alpha(), 1'b0, none);
          sent++;
        end else begin
          if (key_pool.size() != 0 && $urandom_range(0, 99) < 65)
            c = key_pool[$urandom_range(0, key_pool.size() - 1)];
          else
            c = rand_rgb();
          drive_item(CMD_PIXEL, c, rand_rgb(), rand_alpha(), 1'b0, none);
          sent++;
        end
      end
    end

    drain_pixels();
    repeat (ENTRIES + 8) @(posedge clk);
    if (fails == 0) begin
      $display("palette_color_remap_test OK");
    end else begin
      $display("palette_color_remap_test NOT OK");
    end
    $finish;
  end

endmodule
